// File: rtl/core/rsl_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rsl_pkg: shared types and constants of the radial spotlight luminance block
// Holds the fixed arithmetic widths, the spotlight constants and the word that
// flows through the square-root stages.
// ============================================================================
package rsl_pkg;

  // Configuration register widths and the APB port shape.
  localparam int CFG_BITS   = 14;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register index codes, selected by paddr[2].
  typedef enum logic {
    REG_CENTER_X = 1'b0,
    REG_CENTER_Y = 1'b1
  } reg_idx_e;

  // Luminance and factor formats.
  localparam int LUM_BITS = 16;
  localparam int FACTOR_W = 17;
  localparam int LPROD_W  = LUM_BITS + FACTOR_W;

  localparam logic [FACTOR_W-1:0] FAR_FACTOR = 17'd13107;
  localparam logic [FACTOR_W-1:0] UNITY      = 17'd65536;
  localparam int                  RADIUS_SQ  = 25600;

  // Square-root datapath: a 32-bit radicand gives a 16-bit root.
  localparam int SQ_RAD_W    = 32;
  localparam int SQ_ROOT_W   = SQ_RAD_W / 2;
  localparam int SQ_REM_W    = SQ_ROOT_W + 3;
  localparam int SQ_STEPS    = 2;
  localparam int SQ_STAGES   = SQ_ROOT_W / SQ_STEPS;
  localparam int S_KEEP_W    = SQ_ROOT_W - 1;

  // floor(d * 32 / 25) = (d * RECIP_M) >> RECIP_SHIFT for every 16-bit d below 40960.
  localparam int                RECIP_W     = 22;
  localparam logic [RECIP_W-1:0] RECIP_M    = 22'd2684355;
  localparam int                RECIP_SHIFT = 21;
  localparam int                PROD_W      = SQ_ROOT_W + RECIP_W;
  localparam int                QUOT_W      = 16;

  // Stage counts: three distance stages, the root stages, three scale stages.
  localparam int DIST_STAGES  = 3;
  localparam int SCALE_STAGES = 3;
  localparam int PIPE_DEPTH   = DIST_STAGES + SQ_STAGES + SCALE_STAGES;

  // Word carried through the square-root stages.
  typedef struct packed {
    logic                 far;
    logic [LUM_BITS-1:0]  lum;
    logic [SQ_RAD_W-1:0]  rad;
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } sq_word_t;

endpackage

// File: rtl/core/rsl_if.sv
`timescale 1ns / 1ps
// ============================================================================
// rsl_if: valid/ready stream interfaces of the spotlight block
// rsl_pix_if carries one pixel word, rsl_lum_if one scaled luminance word.
// ============================================================================
interface rsl_pix_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic [15:0]           lum_in;

  modport source (output valid, output pix_x, output pix_y, output lum_in, input ready);
  modport sink   (input valid, input pix_x, input pix_y, input lum_in, output ready);
endinterface

interface rsl_lum_if;
  logic        valid;
  logic        ready;
  logic [15:0] lum_out;

  modport source (output valid, output lum_out, input ready);
  modport sink   (input valid, input lum_out, output ready);
endinterface

// File: rtl/core/radial_spotlight_luminance.sv
`timescale 1ns / 1ps
// ============================================================================
// radial_spotlight_luminance: per-pixel spotlight vignette on a luma stream
// Scales each luminance by 1 - d/200 inside radius 160 of a programmable
// centre and by 0.2 beyond it.
// ============================================================================
// Usage:
//   Pixel words enter on pix_i (pix_x, pix_y, lum_in) and scaled words leave
//   on lum_o (lum_out); both are valid/ready channels, a word moves when valid
//   and ready are high at a rising edge. The centre is set over the APB port:
//   center_x at address 0, center_y at address 4, 14-bit two's complement,
//   read back zero-extended. pready is always high.
//   The datapath is a 14-stage pipeline: three stages for the squared
//   distance, eight stages of the square root at two root bits each, and
//   three stages for the factor and the final product. While nothing stalls,
//   one word is taken every clock. Each stage carries its own valid bit and
//   loads when it is empty or its successor moves, so a stalled receiver
//   freezes only the full stages behind it; bubbles are squeezed out and
//   pix_i keeps accepting until every stage holds a word. Reset empties the
//   pipeline and clears both centre registers to zero. Write the centre only
//   while no word is in flight.
// ============================================================================
module radial_spotlight_luminance
  import rsl_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rsl_pix_if.sink               pix_i,
  rsl_lum_if.source             lum_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // --------------------------------------------------------------------------
  // Configuration registers. The index is paddr[2]; the low bits are ignored.
  // --------------------------------------------------------------------------
  logic [CFG_BITS-1:0] center_x_q, center_y_q;
  reg_idx_e            reg_idx;
  logic                cfg_wr;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CENTER_X: center_x_q <= pwdata[CFG_BITS-1:0];
        REG_CENTER_Y: center_y_q <= pwdata[CFG_BITS-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X: prdata = APB_DATA_W'(center_x_q);
      REG_CENTER_Y: prdata = APB_DATA_W'(center_y_q);
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control. A stage loads when it is empty or the next one moves.
  // --------------------------------------------------------------------------
  logic [PIPE_DEPTH-1:0] valid_q, valid_d, en;

  always_comb begin
    en[PIPE_DEPTH-1] = !valid_q[PIPE_DEPTH-1] || lum_o.ready;
    for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  assign valid_d     = {valid_q[PIPE_DEPTH-2:0], pix_i.valid};
  assign pix_i.ready = en[0];
  assign lum_o.valid = valid_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_d[i];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath.
  // --------------------------------------------------------------------------
  sq_word_t sq_w [SQ_STAGES+1];

  rsl_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i      (clk_i),
    .en_i       (en[DIST_STAGES-1:0]),
    .pix_x_i    (pix_i.pix_x[COORD_BITS-1:0]),
    .pix_y_i    (pix_i.pix_y[COORD_BITS-1:0]),
    .lum_i      (pix_i.lum_in),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .sq_o       (sq_w[0])
  );

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
    rsl_sqrt_stage u_sqrt_stage (
      .clk_i (clk_i),
      .en_i  (en[DIST_STAGES+g]),
      .sq_i  (sq_w[g]),
      .sq_o  (sq_w[g+1])
    );
  end

  rsl_scale u_scale (
    .clk_i (clk_i),
    .en_i  (en[PIPE_DEPTH-1 -: SCALE_STAGES]),
    .sq_i  (sq_w[SQ_STAGES]),
    .lum_o (lum_o.lum_out)
  );

endmodule

// File: rtl/core/rsl_dist.sv
`timescale 1ns / 1ps
// ============================================================================
// rsl_dist: squared distance front end
// Three stages: absolute offsets, squares, sum with the far-radius test.
// ============================================================================
module rsl_dist
  import rsl_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                       clk_i,
  input  logic [DIST_STAGES-1:0]     en_i,
  input  logic [COORD_BITS-1:0]      pix_x_i,
  input  logic [COORD_BITS-1:0]      pix_y_i,
  input  logic [LUM_BITS-1:0]        lum_i,
  input  logic [CFG_BITS-1:0]        center_x_i,
  input  logic [CFG_BITS-1:0]        center_y_i,
  output sq_word_t                   sq_o
);

  localparam int DIFF_W = ((COORD_BITS > CFG_BITS - 1) ? COORD_BITS : CFG_BITS - 1) + 2;
  localparam int ABS_W  = DIFF_W - 1;
  localparam int SQ_W   = 2 * ABS_W;
  localparam int SUM_W  = SQ_W + 1;

  logic [DIFF_W-1:0]   diff_x, diff_y, neg_x, neg_y;
  logic [ABS_W-1:0]    adx_d, ady_d, adx_q, ady_q;
  logic [LUM_BITS-1:0] lum_a_q, lum_b_q;
  logic [SQ_W-1:0]     sqx_d, sqy_d, sqx_q, sqy_q;
  logic [SUM_W-1:0]    sum;
  sq_word_t            sq_d, sq_q;

  // Pixel is zero-extended, the centre sign-extended; the difference is exact.
  always_comb begin
    diff_x = {{(DIFF_W-COORD_BITS){1'b0}}, pix_x_i}
           - {{(DIFF_W-CFG_BITS){center_x_i[CFG_BITS-1]}}, center_x_i};
    diff_y = {{(DIFF_W-COORD_BITS){1'b0}}, pix_y_i}
           - {{(DIFF_W-CFG_BITS){center_y_i[CFG_BITS-1]}}, center_y_i};
    neg_x  = -diff_x;
    neg_y  = -diff_y;
    adx_d  = diff_x[DIFF_W-1] ? neg_x[ABS_W-1:0] : diff_x[ABS_W-1:0];
    ady_d  = diff_y[DIFF_W-1] ? neg_y[ABS_W-1:0] : diff_y[ABS_W-1:0];
  end

  assign sqx_d = SQ_W'(adx_q) * SQ_W'(adx_q);
  assign sqy_d = SQ_W'(ady_q) * SQ_W'(ady_q);

  // Only sums below the radius use the root, and those fit in S_KEEP_W bits.
  always_comb begin
    sum       = SUM_W'(sqx_q) + SUM_W'(sqy_q);
    sq_d.far  = (sum >= SUM_W'(RADIUS_SQ));
    sq_d.lum  = lum_b_q;
    sq_d.rad  = {1'b0, sum[S_KEEP_W-1:0], {(SQ_RAD_W-S_KEEP_W-1){1'b0}}};
    sq_d.rem  = '0;
    sq_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      adx_q   <= adx_d;
      ady_q   <= ady_d;
      lum_a_q <= lum_i;
    end
    if (en_i[1]) begin
      sqx_q   <= sqx_d;
      sqy_q   <= sqy_d;
      lum_b_q <= lum_a_q;
    end
    if (en_i[2]) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

// File: rtl/core/rsl_sqrt_stage.sv
`timescale 1ns / 1ps
// ============================================================================
// rsl_sqrt_stage: one stage of the restoring square root
// Resolves SQ_STEPS root bits from the next radicand digits.
// ============================================================================
module rsl_sqrt_stage
  import rsl_pkg::*;
(
  input  logic     clk_i,
  input  logic     en_i,
  input  sq_word_t sq_i,
  output sq_word_t sq_o
);

  sq_word_t sq_d, sq_q;

  always_comb begin
    logic [SQ_REM_W-1:0] r;
    logic [SQ_REM_W-1:0] t;
    sq_d = sq_i;
    for (int k = 0; k < SQ_STEPS; k++) begin
      r = {sq_d.rem[SQ_REM_W-3:0], sq_d.rad[SQ_RAD_W-1 -: 2]};
      t = {1'b0, sq_d.root, 2'b01};
      if (r >= t) begin
        sq_d.rem  = r - t;
        sq_d.root = {sq_d.root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
        sq_d.rem  = r;
        sq_d.root = {sq_d.root[SQ_ROOT_W-2:0], 1'b0};
      end
      sq_d.rad = {sq_d.rad[SQ_RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

// File: rtl/core/rsl_scale.sv
`timescale 1ns / 1ps
// ============================================================================
// rsl_scale: factor and luminance scaling back end
// Three stages: reciprocal product, factor select, luminance product.
// ============================================================================
module rsl_scale
  import rsl_pkg::*;
(
  input  logic                    clk_i,
  input  logic [SCALE_STAGES-1:0] en_i,
  input  sq_word_t                sq_i,
  output logic [LUM_BITS-1:0]     lum_o
);

  logic [PROD_W-1:0]   prod_q;
  logic                far_q;
  logic [LUM_BITS-1:0] lum_a_q, lum_b_q, lum_out_q;
  logic [QUOT_W-1:0]   quot;
  logic [FACTOR_W-1:0] factor_d, factor_q;
  logic [LPROD_W-1:0]  lprod;

  // d * 32 / 25 by multiplying with a scaled reciprocal.
  assign quot     = prod_q[RECIP_SHIFT +: QUOT_W];
  assign factor_d = far_q ? FAR_FACTOR : (UNITY - FACTOR_W'(quot));
  assign lprod    = LPROD_W'(lum_b_q) * LPROD_W'(factor_q);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q  <= PROD_W'(sq_i.root) * PROD_W'(RECIP_M);
      far_q   <= sq_i.far;
      lum_a_q <= sq_i.lum;
    end
    if (en_i[1]) begin
      factor_q <= factor_d;
      lum_b_q  <= lum_a_q;
    end
    if (en_i[2]) begin
      lum_out_q <= lprod[LUM_BITS +: LUM_BITS];
    end
  end

  assign lum_o = lum_out_q;

endmodule

// File: rtl/core/rsl_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// rsl_checker: port-level checks of the spotlight block
// Watches the output channel and the configuration port over time.
// ============================================================================
module rsl_checker
  import rsl_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [LUM_BITS-1:0]   lum_out_i,
  input logic                  psel_i,
  input logic                  penable_i,
  input logic                  pwrite_i,
  input logic [APB_ADDR_W-1:0] paddr_i,
  input logic [APB_DATA_W-1:0] pwdata_i,
  input logic [APB_DATA_W-1:0] prdata_i
);

  // A waiting result word stays offered.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // A waiting result word keeps its value.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(lum_out_i))
    else $error("result word changed while stalled");

  // A centre write is read back in the next cycle.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel_i && penable_i && pwrite_i) ##1
    (psel_i && !pwrite_i && paddr_i[2] == $past(paddr_i[2]))
    |-> prdata_i[CFG_BITS-1:0] == $past(pwdata_i[CFG_BITS-1:0]))
    else $error("centre register read back wrong value");

  // Read data above the register width is always zero.
  a_cfg_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata_i[APB_DATA_W-1:CFG_BITS] == '0)
    else $error("read data has bits set above the register");

endmodule

bind radial_spotlight_luminance rsl_checker u_rsl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (lum_o.valid),
  .out_ready_i (lum_o.ready),
  .lum_out_i   (lum_o.lum_out),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);
